// ----- design/gww_pkg.sv -----
// ----------------------------------------------------------------------------
// Greedy word wrap package
// Shared widths, limits, item and span types for the line breaker.
// ----------------------------------------------------------------------------
package gww_pkg;

    // Field widths
    localparam int POS_W     = 17;
    localparam int CLUSTER_W = 6;
    localparam int CNT_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 10;

    // Limits
    localparam logic [POS_W-1:0]     MAX_TEXT_BYTES    = 17'd65536;
    localparam logic [CLUSTER_W-1:0] MAX_CLUSTER_BYTES = 6'd32;
    localparam logic [CNT_W-1:0]     CNT_MAX           = 10'd1023;

    // Configuration reset values and register indexes
    localparam logic [CNT_W-1:0]     WRAP_WIDTH_RST = 10'd80;
    localparam logic                 MULTILINE_RST  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULTILINE  = 1'd1;

    // Item queue between front and back
    localparam int ITEM_DEPTH = 2;
    localparam int ITEM_PTR_W = 1;
    localparam int ITEM_CNT_W = 2;

    // Span queue at the output
    localparam int SPAN_DEPTH = 4;
    localparam int SPAN_PTR_W = 2;
    localparam int SPAN_CNT_W = 3;
    localparam logic [SPAN_CNT_W-1:0] SPAN_POP_LIMIT = 3'(SPAN_DEPTH - 2);

    // Cluster classification, newline wins over blank
    typedef enum logic [1:0] {
        KIND_WORD,
        KIND_BLANK,
        KIND_NEWLINE
    } kind_t;

    typedef struct packed {
        logic [CLUSTER_W-1:0] bytes;
        kind_t                kind;
        logic                 last;
    } item_t;

    typedef struct packed {
        logic             fin;
        logic [POS_W-1:0] line_end;
        logic [POS_W-1:0] line_start;
    } span_t;

    typedef struct packed {
        logic [CNT_W-1:0] wrap_width;
        logic             multiline;
    } cfg_t;

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

// ----- design/greedy_word_wrap_line_breaker_top.sv -----
// ----------------------------------------------------------------------------
// Greedy word wrap line breaker
// Turns a stream of classified grapheme clusters into line spans.
// ----------------------------------------------------------------------------
// The block takes one cluster per clock cycle while the span queue has room
// and returns line spans as byte offsets [line_start, line_end). Clusters pass
// a front register, a two-entry item queue and the line logic, which updates
// its state once per cluster; spans leave through a four-entry span queue, one
// span per cycle while the receiver is ready. A cluster produces at most two
// spans (a newline that ends the text in multi-line mode, or a wrap on the
// final cluster followed by the trailing span), so the sustained rate is one
// cluster per cycle while the receiver keeps up, and a cluster that yields two
// spans needs two span transfers at the output. Write wrap_width and multiline
// on the configuration channel only while no text is in flight; the channel is
// always ready.
module greedy_word_wrap_line_breaker_top import gww_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // cluster input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [5:0] cluster_bytes, [7:6] zero
    input  logic [1:0]            s_axis_tuser,  // [0] is_newline, [1] is_blank
    input  logic                  s_axis_tlast,  // is_last
    // span output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,  // [16:0] line_start, [33:17] line_end
    output logic                  m_axis_tlast   // is_final
);

    cfg_t  cfg_reg;
    logic  fr_valid;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    item_t fr_item;
    item_t q_item;
    span_t span;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wrap_width <= WRAP_WIDTH_RST;
            cfg_reg.multiline  <= MULTILINE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WRAP_WIDTH: cfg_reg.wrap_width <= cfg_data;
                REG_MULTILINE:  cfg_reg.multiline  <= cfg_data[0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    gww_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_bytes   (s_axis_tdata[CLUSTER_W-1:0]),
        .in_newline (s_axis_tuser[0]),
        .in_blank   (s_axis_tuser[1]),
        .in_last    (s_axis_tlast),
        .out_valid  (fr_valid),
        .out_ready  (!q_full),
        .out_item   (fr_item)
    );

    gww_item_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fr_valid),
        .push_item (fr_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (q_item)
    );

    gww_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_avail (!q_empty),
        .item       (q_item),
        .item_pop   (q_pop),
        .span_valid (m_axis_tvalid),
        .span_ready (m_axis_tready),
        .span       (span)
    );

    // Pack the span onto the output stream
    assign m_axis_tdata = {6'd0, span.line_end, span.line_start};
    assign m_axis_tlast = span.fin;

endmodule

// ----- design/gww_front.sv -----
// ----------------------------------------------------------------------------
// Greedy word wrap front end
// Accepts clusters, clamps the byte length and classifies each cluster.
// ----------------------------------------------------------------------------
module gww_front import gww_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CLUSTER_W-1:0] in_bytes,
    input  logic                 in_newline,
    input  logic                 in_blank,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output item_t                out_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    // Classify and clamp the incoming cluster
    always_comb begin
        item_next.bytes = (in_bytes > MAX_CLUSTER_BYTES) ? MAX_CLUSTER_BYTES : in_bytes;
        item_next.last  = in_last;
        if (in_newline) begin
            item_next.kind = KIND_NEWLINE;
        end else if (in_blank) begin
            item_next.kind = KIND_BLANK;
        end else begin
            item_next.kind = KIND_WORD;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Hold the classified item until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- design/gww_item_queue.sv -----
// ----------------------------------------------------------------------------
// Greedy word wrap item queue
// Two-entry queue that decouples the front end from the line logic.
// ----------------------------------------------------------------------------
module gww_item_queue import gww_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t pop_item
);

    item_t                 mem_reg [ITEM_DEPTH];
    logic [ITEM_PTR_W-1:0] wptr_reg;
    logic [ITEM_PTR_W-1:0] rptr_reg;
    logic [ITEM_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == ITEM_CNT_W'(ITEM_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + ITEM_CNT_W'(do_push) - ITEM_CNT_W'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/gww_back.sv -----
// ----------------------------------------------------------------------------
// Greedy word wrap line logic
// Tracks line and word state per cluster and queues the line spans.
// ----------------------------------------------------------------------------
module gww_back import gww_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  item_avail,
    input  item_t item,
    output logic  item_pop,
    output logic  span_valid,
    input  logic  span_ready,
    output span_t span
);

    // Per-text state
    logic [POS_W-1:0] byte_pos_reg,    byte_pos_next;
    logic [POS_W-1:0] line_begin_reg,  line_begin_next;
    logic [POS_W-1:0] word_begin_reg,  word_begin_next;
    logic             word_open_reg,   word_open_next;
    logic [CNT_W-1:0] word_count_reg,  word_count_next;
    logic [CNT_W-1:0] line_count_reg,  line_count_next;
    logic             any_emitted_reg, any_emitted_next;
    logic             stopped_reg,     stopped_next;

    // Span queue
    span_t                 smem_reg [SPAN_DEPTH];
    logic [SPAN_PTR_W-1:0] swptr_reg;
    logic [SPAN_PTR_W-1:0] srptr_reg;
    logic [SPAN_CNT_W-1:0] scount_reg;

    span_t            p0, p1;
    logic             p0_v, p1_v;
    logic [POS_W:0]   sum;
    logic [POS_W-1:0] off, endp;
    logic             blank;
    logic             span_pop;

    // Take an item only when the span queue has room for two spans
    assign item_pop   = item_avail && (scount_reg <= SPAN_POP_LIMIT);
    assign span_valid = (scount_reg != '0);
    assign span       = smem_reg[srptr_reg];
    assign span_pop   = span_valid && span_ready;

    // Line and word update for one cluster
    always_comb begin
        byte_pos_next    = byte_pos_reg;
        line_begin_next  = line_begin_reg;
        word_begin_next  = word_begin_reg;
        word_open_next   = word_open_reg;
        word_count_next  = word_count_reg;
        line_count_next  = line_count_reg;
        any_emitted_next = any_emitted_reg;
        stopped_next     = stopped_reg;
        p0   = '0;
        p1   = '0;
        p0_v = 1'b0;
        p1_v = 1'b0;

        off   = byte_pos_reg;
        sum   = {1'b0, off} + (POS_W+1)'(item.bytes);
        endp  = (sum > {1'b0, MAX_TEXT_BYTES}) ? MAX_TEXT_BYTES : sum[POS_W-1:0];
        blank = (item.kind == KIND_BLANK);

        if (!stopped_reg) begin
            case (item.kind)
                KIND_NEWLINE: begin
                    p0_v = 1'b1;
                    p0   = '{fin: !cfg.multiline, line_end: off, line_start: line_begin_reg};
                    if (item.last && cfg.multiline) begin
                        p1_v = 1'b1;
                        p1   = '{fin: 1'b1, line_end: endp, line_start: endp};
                    end
                    word_open_next   = 1'b0;
                    line_begin_next  = endp;
                    line_count_next  = '0;
                    any_emitted_next = 1'b1;
                    if (!cfg.multiline) begin
                        stopped_next = 1'b1;
                    end
                end
                KIND_WORD, KIND_BLANK: begin
                    if (line_count_reg >= cfg.wrap_width) begin
                        if (!cfg.multiline) begin
                            stopped_next = 1'b1;
                        end else if (word_open_reg && (word_begin_reg != line_begin_reg)) begin
                            // carry the open word onto the next line
                            p0_v = 1'b1;
                            p0   = '{fin: 1'b0, line_end: word_begin_reg,
                                     line_start: line_begin_reg};
                            line_begin_next = word_begin_reg;
                            line_count_next = inc_sat(word_count_reg);
                            if (blank) begin
                                word_open_next  = 1'b0;
                                word_count_next = '0;
                            end else begin
                                word_count_next = inc_sat(word_count_reg);
                            end
                            any_emitted_next = 1'b1;
                        end else begin
                            // hard break at this cluster
                            p0_v = 1'b1;
                            p0   = '{fin: 1'b0, line_end: off, line_start: line_begin_reg};
                            line_begin_next = off;
                            if (blank) begin
                                word_open_next  = 1'b0;
                                word_count_next = '0;
                                line_count_next = '0;
                            end else begin
                                word_open_next  = 1'b1;
                                word_begin_next = off;
                                word_count_next = CNT_W'(1);
                                line_count_next = CNT_W'(1);
                            end
                            any_emitted_next = 1'b1;
                        end
                    end else if (!blank) begin
                        if (!word_open_reg) begin
                            word_open_next  = 1'b1;
                            word_begin_next = off;
                            word_count_next = CNT_W'(1);
                        end else begin
                            word_count_next = inc_sat(word_count_reg);
                        end
                        line_count_next = inc_sat(line_count_reg);
                    end else begin
                        word_open_next  = 1'b0;
                        word_count_next = '0;
                        line_count_next = inc_sat(line_count_reg);
                    end
                end
                default: begin
                    stopped_next = stopped_reg;
                end
            endcase
        end

        byte_pos_next = endp;

        // Close the text: trailing span or mark the last span final
        if (item.last) begin
            if ((line_begin_next < endp) && (cfg.multiline || !any_emitted_next)) begin
                if (!p0_v) begin
                    p0_v = 1'b1;
                    p0   = '{fin: 1'b1, line_end: endp, line_start: line_begin_next};
                end else if (!p1_v) begin
                    p1_v = 1'b1;
                    p1   = '{fin: 1'b1, line_end: endp, line_start: line_begin_next};
                end
            end else if (p1_v) begin
                p1.fin = 1'b1;
            end else if (p0_v) begin
                p0.fin = 1'b1;
            end
            byte_pos_next    = '0;
            line_begin_next  = '0;
            word_begin_next  = '0;
            word_open_next   = 1'b0;
            word_count_next  = '0;
            line_count_next  = '0;
            any_emitted_next = 1'b0;
            stopped_next     = 1'b0;
        end
    end

    // Advance per-text state on each item taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg    <= '0;
            line_begin_reg  <= '0;
            word_begin_reg  <= '0;
            word_open_reg   <= 1'b0;
            word_count_reg  <= '0;
            line_count_reg  <= '0;
            any_emitted_reg <= 1'b0;
            stopped_reg     <= 1'b0;
        end else if (item_pop) begin
            byte_pos_reg    <= byte_pos_next;
            line_begin_reg  <= line_begin_next;
            word_begin_reg  <= word_begin_next;
            word_open_reg   <= word_open_next;
            word_count_reg  <= word_count_next;
            line_count_reg  <= line_count_next;
            any_emitted_reg <= any_emitted_next;
            stopped_reg     <= stopped_next;
        end
    end

    // Span queue pointers; up to two spans are pushed per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swptr_reg  <= '0;
            srptr_reg  <= '0;
            scount_reg <= '0;
        end else begin
            swptr_reg  <= swptr_reg + SPAN_PTR_W'(item_pop && p0_v)
                                    + SPAN_PTR_W'(item_pop && p1_v);
            srptr_reg  <= srptr_reg + SPAN_PTR_W'(span_pop);
            scount_reg <= scount_reg + SPAN_CNT_W'(item_pop && p0_v)
                                     + SPAN_CNT_W'(item_pop && p1_v)
                                     - SPAN_CNT_W'(span_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop && p0_v) begin
            smem_reg[swptr_reg] <= p0;
        end
        if (item_pop && p1_v) begin
            smem_reg[swptr_reg + 1'b1] <= p1;
        end
    end

endmodule

// ----- verif/tb_greedy_word_wrap_line_breaker_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greedy word wrap line breaker testbench
// Drives classified clusters into the line breaker and checks every line span
// it returns against a cycle-free model of the wrapping rules kept here.
// Directed texts cover carry-over and hard wraps, newlines, cluster sizes,
// single-line mode and width changes; random texts follow under varied
// sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_greedy_word_wrap_line_breaker_top;
    import gww_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_TICKS = 12;
    localparam int HOLD_TICKS   = 400;

    typedef struct {
        logic [POS_W-1:0] start_off;
        logic [POS_W-1:0] end_off;
        logic             fin;
    } span_rec_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_WRAP_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;  // [5:0] cluster_bytes, [7:6] zero
    logic [1:0]            s_axis_tuser  = '0;  // [0] is_newline, [1] is_blank
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;        // [16:0] line_start, [33:17] line_end
    logic                  m_axis_tlast;

    // Line state as the block should hold it
    logic [CNT_W-1:0] width_q     = WRAP_WIDTH_RST;
    logic             multi_q     = MULTILINE_RST;
    int               text_pos    = 0;
    int               line_from   = 0;
    int               word_from   = 0;
    logic             word_live   = 1'b0;
    logic [CNT_W-1:0] word_len    = '0;
    logic [CNT_W-1:0] line_len    = '0;
    logic             spanned     = 1'b0;
    logic             halted      = 1'b0;

    span_rec_t spans_due[$];
    span_rec_t fresh_spans[2];
    int        fresh_n       = 0;
    int        mismatches    = 0;
    int        clusters_sent = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        hold_left     = 0;
    int        quiet_cycles  = 0;

    greedy_word_wrap_line_breaker_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Counters stop at their ceiling
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    // At most two spans per cluster; a third is dropped
    function void add_span(input int s, input int e, input logic fin);
        if (fresh_n < 2) begin
            fresh_spans[fresh_n] = '{start_off: POS_W'(s), end_off: POS_W'(e), fin: fin};
            fresh_n++;
        end
    endfunction

    // Advance the line state by one cluster and queue the spans it closes
    task automatic break_cluster(input logic [CLUSTER_W-1:0] raw, input logic nl,
                                 input logic blank, input logic last);
        int nbytes;
        int off;
        int endp;
        nbytes = (raw > MAX_CLUSTER_BYTES) ? int'(MAX_CLUSTER_BYTES) : int'(raw);
        off = text_pos;
        endp = off + nbytes;
        if (endp > MAX_TEXT_BYTES)
            endp = MAX_TEXT_BYTES;
        fresh_n = 0;

        if (!halted) begin
            if (nl) begin
                add_span(line_from, off, !multi_q);
                if (last && multi_q)
                    add_span(endp, endp, 1'b1);
                word_live = 1'b0;
                line_from = endp;
                line_len = '0;
                spanned = 1'b1;
                if (!multi_q)
                    halted = 1'b1;
            end else if (line_len >= width_q) begin
                if (!multi_q) begin
                    halted = 1'b1;
                end else if (word_live && word_from != line_from) begin
                    // move the open word down to a fresh line
                    add_span(line_from, word_from, 1'b0);
                    line_from = word_from;
                    line_len = sat_inc(word_len);
                    if (blank) begin
                        word_live = 1'b0;
                        word_len = '0;
                    end else begin
                        word_len = sat_inc(word_len);
                    end
                    spanned = 1'b1;
                end else begin
                    // word fills the whole line: cut it here
                    add_span(line_from, off, 1'b0);
                    line_from = off;
                    if (blank) begin
                        word_live = 1'b0;
                        word_len = '0;
                        line_len = '0;
                    end else begin
                        word_live = 1'b1;
                        word_from = off;
                        word_len = CNT_W'(1);
                        line_len = CNT_W'(1);
                    end
                    spanned = 1'b1;
                end
            end else if (!blank) begin
                if (!word_live) begin
                    word_live = 1'b1;
                    word_from = off;
                    word_len = CNT_W'(1);
                end else begin
                    word_len = sat_inc(word_len);
                end
                line_len = sat_inc(line_len);
            end else begin
                word_live = 1'b0;
                word_len = '0;
                line_len = sat_inc(line_len);
            end
        end

        text_pos = endp;

        if (last) begin
            if (line_from < endp && (multi_q || !spanned))
                add_span(line_from, endp, 1'b1);
            else if (fresh_n > 0)
                fresh_spans[fresh_n-1].fin = 1'b1;
            text_pos = 0;
            line_from = 0;
            word_from = 0;
            word_live = 1'b0;
            word_len = '0;
            line_len = '0;
            spanned = 1'b0;
            halted = 1'b0;
        end

        for (int k = 0; k < fresh_n; k++)
            spans_due = {spans_due, fresh_spans[k]};
    endtask

    // Offer one cluster, with random idle cycles ahead of it
    task automatic send_cluster(input logic [CLUSTER_W-1:0] nbytes, input logic nl,
                                input logic blank, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, nbytes};
        s_axis_tuser  <= {blank, nl};
        s_axis_tlast  <= last;
        do
            @(posedge aclk);
        while (!(s_axis_tvalid && s_axis_tready));
        clusters_sent++;
        break_cluster(nbytes, nl, blank, last);
    endtask

    // Letters are one-byte word clusters; the rest are marked below
    task automatic send_pattern(input string pat, input logic ends_text);
        logic [CLUSTER_W-1:0] nb;
        logic                 nl;
        logic                 bl;
        for (int i = 0; i < pat.len(); i++) begin
            nl = 1'b0;
            bl = 1'b0;
            nb = CLUSTER_W'(1);
            case (pat[i])
                " ": bl = 1'b1;
                "|": nl = 1'b1;
                "*": begin   // newline that is also flagged blank
                    nl = 1'b1;
                    bl = 1'b1;
                    nb = CLUSTER_W'(2);
                end
                "B": begin   // blank with an odd byte length
                    bl = 1'b1;
                    nb = CLUSTER_W'(5);
                end
                "O": nb = CLUSTER_W'(63);
                "X": nb = CLUSTER_W'(32);
                "Z": nb = '0;
                default: nb = CLUSTER_W'(1);
            endcase
            send_cluster(nb, nl, bl, ends_text && (i == pat.len() - 1));
        end
    endtask

    // Drop valid, wait for every span owed, then let the pipeline settle
    task automatic wait_spans_done();
        s_axis_tvalid <= 1'b0;
        while (spans_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Write both registers back to back; only while nothing is in flight
    task automatic apply_config(input logic [CNT_W-1:0] w, input logic ml);
        cfg_valid <= 1'b1;
        cfg_index <= REG_WRAP_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_index <= REG_MULTILINE;
        cfg_data  <= CFG_DATA_W'(ml);
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        width_q = w;
        multi_q = ml;
    endtask

    task automatic test_carry_over();
        apply_config(CNT_W'(4), 1'b1);
        send_pattern("a bcd e", 1'b1);   // word carried, then hard cut
        send_pattern("a bc x", 1'b1);    // blank arrives on a full line
        wait_spans_done();
    endtask

    task automatic test_hard_break();
        apply_config(CNT_W'(4), 1'b1);
        send_pattern("abcdef", 1'b1);
        send_pattern("abcd e", 1'b1);    // blank on the cut starts an empty line
        wait_spans_done();
    endtask

    task automatic test_newline();
        apply_config(CNT_W'(4), 1'b1);
        send_pattern("Ba*|", 1'b1);      // trailing newline adds an empty line
        wait_spans_done();
    endtask

    task automatic test_single_line();
        apply_config(CNT_W'(3), 1'b0);
        send_pattern("abcd", 1'b1);      // stop at wrap, whole text at the end
        send_pattern("a|b", 1'b1);
        wait_spans_done();
    endtask

    task automatic test_width_zero();
        apply_config('0, 1'b1);
        send_pattern("ab", 1'b1);
        wait_spans_done();
    endtask

    task automatic test_width_change();
        apply_config(CNT_W'(10), 1'b1);
        send_pattern("abcde", 1'b0);
        wait_spans_done();
        // narrow the line under an open text; zero-byte cluster ends it
        apply_config(CNT_W'(2), 1'b1);
        send_pattern("OxZ", 1'b1);
        wait_spans_done();
    endtask

    task automatic test_long_text();
        apply_config(CNT_MAX, 1'b1);
        for (int i = 0; i < 2060; i++)
            send_cluster(CLUSTER_W'($urandom_range(32, 63)), 1'b0,
                         $urandom_range(0, 49) == 0, i == 2059);
        wait_spans_done();
    endtask

    task automatic test_backpressure();
        apply_config(CNT_W'(1), 1'b1);
        hold_left <= HOLD_TICKS;
        send_pattern("abcdefghijklmnopqrstuvwxyzabcd", 1'b1);
        wait_spans_done();
    endtask

    // Mostly word/blank/newline texts, some with fully random fields
    task automatic send_random_text();
        int                   len;
        int                   r;
        logic                 noisy;
        logic [CLUSTER_W-1:0] nb;
        logic                 nl;
        logic                 bl;
        len = $urandom_range(1, 40);
        noisy = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
            if (noisy) begin
                nb = CLUSTER_W'($urandom);
                nl = 1'($urandom);
                bl = 1'($urandom);
            end else begin
                r = $urandom_range(0, 99);
                nl = (r >= 95);
                bl = (r >= 72 && r < 95);
                nb = ($urandom_range(0, 9) == 0) ? CLUSTER_W'($urandom)
                                                  : CLUSTER_W'($urandom_range(1, 4));
                if (bl && $urandom_range(0, 3) != 0)
                    nb = CLUSTER_W'(1);
            end
            send_cluster(nb, nl, bl, i == len - 1);
        end
    endtask

    task automatic test_random();
        int               mark;
        int               r;
        logic [CNT_W-1:0] w;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 80; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            r = $urandom_range(0, 9);
            if (r == 0)
                w = '0;
            else if (r == 1)
                w = CNT_MAX;
            else if (r == 2)
                w = CNT_W'(1);
            else
                w = CNT_W'($urandom_range(2, 16));
            apply_config(w, $urandom_range(0, 3) != 0);
            mark = clusters_sent;
            while (clusters_sent - mark < 20)
                send_random_text();
            wait_spans_done();
        end
    endtask

    // Receiver: long hold when asked, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each span transfer with the oldest one owed
    always @(posedge aclk) begin : span_check
        span_rec_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (spans_due.size() == 0) begin
                $error("span with none expected: line_start %0d line_end %0d",
                       m_axis_tdata[16:0], m_axis_tdata[33:17]);
                mismatches++;
            end else begin
                want = spans_due.pop_front();
                if (m_axis_tdata[16:0] !== want.start_off) begin
                    $error("line_start expected %0d actual %0d",
                           want.start_off, m_axis_tdata[16:0]);
                    mismatches++;
                end
                if (m_axis_tdata[33:17] !== want.end_off) begin
                    $error("line_end expected %0d actual %0d",
                           want.end_off, m_axis_tdata[33:17]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.fin) begin
                    $error("is_final expected %0d actual %0d", want.fin, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("greedy_word_wrap_line_breaker_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_carry_over();
        test_hard_break();
        test_newline();
        test_single_line();
        test_width_zero();
        test_width_change();
        test_long_text();
        test_backpressure();
        test_random();
        if (mismatches == 0 && spans_due.size() == 0)
            $display("greedy_word_wrap_line_breaker_top: match");
        else
            $display("greedy_word_wrap_line_breaker_top: mismatch");
        $finish;
    end

endmodule
